FILE: design/tcw_pkg.sv
// Shared constants, types and helper functions for the text console writer.
// Depends on nothing; tcw_seq and text_console_writer import it.
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_SPACES = 4;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = ATTR_W + CHAR_W;

    // Derived widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int PTR_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        cell_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] cursor_pos;
        cell_t            cell_data;
    } result_t;

    function automatic addr_t cell_index(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    function automatic logic [POS_W-1:0] linear_pos(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [31:0] lin;
        lin = 32'(row) * 32'(COLUMNS) + 32'(col);
        return lin[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/tcw_cell_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/tcw_seq.sv
// Sequencer of the text console writer: cursor, item decode and memory sweeps.
// Depends on tcw_pkg; drives the cell RAM through a mem_req_t.
`default_nettype none

module tcw_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [tcw_pkg::FUNC_W-1:0]     s_func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     s_char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]    s_read_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]     attr,
    input  wire logic                           out_free,
    input  wire tcw_pkg::cell_t                 rd_data,
    output tcw_pkg::mem_req_t                   mem_req,
    output tcw_pkg::result_t                    result
);

    import tcw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GLYPH = 3'd1;
    localparam logic [2:0] ST_BLANK = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [1:0] SW_INIT   = 2'd0;
    localparam logic [1:0] SW_CLEAR  = 2'd1;
    localparam logic [1:0] SW_SCROLL = 2'd2;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mode_reg,  mode_next;
    logic [PTR_W-1:0]  ptr_reg,   ptr_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [TAB_W-1:0]  tab_reg,   tab_next;
    logic [CHAR_W-1:0] char_reg,  char_next;
    cell_t             data_reg,  data_next;

    addr_t             cur_idx;
    logic [ATTR_W-1:0] blank_attr;
    logic [TAB_W-1:0]  tab_dec;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ptr_next   = ptr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        tab_next   = tab_reg;
        char_next  = char_reg;
        data_next  = data_reg;

        cur_idx    = cell_index(row_reg, col_reg);
        blank_attr = (mode_reg == SW_INIT) ? RESET_ATTR : attr;
        tab_dec    = tab_reg - 1'b1;

        s_ready           = (state_reg == ST_IDLE);
        mem_req           = '0;
        result.valid      = 1'b0;
        result.cursor_pos = linear_pos(row_reg, col_reg);
        result.cell_data  = data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next  = '0;
                    state_next = ST_DONE;
                    case (s_func)
                        FUNC_PUT: begin
                            case (s_char_code)
                                CHAR_NEWLINE: begin
                                    col_next = '0;
                                    tab_next = '0;
                                    if (row_reg == ROW_LAST) begin
                                        mode_next  = SW_SCROLL;
                                        ptr_next   = '0;
                                        state_next = ST_SWEEP;
                                    end else begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end
                                CHAR_RETURN: begin
                                    col_next = '0;
                                end
                                CHAR_BACKSPACE: begin
                                    // top-left corner: nothing moves, nothing blanked
                                    if (col_reg != '0 || row_reg != '0) begin
                                        if (col_reg == '0) begin
                                            col_next = COL_LAST;
                                            row_next = row_reg - 1'b1;
                                        end else begin
                                            col_next = col_reg - 1'b1;
                                        end
                                        state_next = ST_BLANK;
                                    end
                                end
                                CHAR_TAB: begin
                                    char_next  = CHAR_SPACE;
                                    tab_next   = TAB_W'(TAB_SPACES);
                                    state_next = ST_GLYPH;
                                end
                                default: begin
                                    char_next  = s_char_code;
                                    tab_next   = TAB_W'(1);
                                    state_next = ST_GLYPH;
                                end
                            endcase
                        end
                        FUNC_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            tab_next   = '0;
                            mode_next  = SW_CLEAR;
                            ptr_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        FUNC_READ: begin
                            if (32'(s_read_index) < 32'(CELL_COUNT)) begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ADDR_W'(s_read_index);
                                state_next    = ST_READ;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_GLYPH: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_idx;
                mem_req.wdata = {attr, char_reg};
                tab_next      = tab_dec;
                state_next    = (tab_dec != '0) ? ST_GLYPH : ST_DONE;
                if (col_reg == COL_LAST) begin
                    col_next = '0;
                    if (row_reg == ROW_LAST) begin
                        mode_next  = SW_SCROLL;
                        ptr_next   = '0;
                        state_next = ST_SWEEP;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end

            ST_BLANK: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_idx;
                mem_req.wdata = {attr, {CHAR_W{1'b0}}};
                state_next    = ST_DONE;
            end

            ST_SWEEP: begin
                // read one row ahead; the write trails one address behind, using the registered read data
                mem_req.re    = (mode_reg == SW_SCROLL) && (ptr_reg < PTR_W'(COPY_COUNT));
                mem_req.raddr = ADDR_W'(ptr_reg + PTR_W'(COLUMNS));
                mem_req.we    = (ptr_reg != '0);
                mem_req.waddr = ADDR_W'(ptr_reg - 1'b1);
                if ((mode_reg == SW_SCROLL) && (ptr_reg <= PTR_W'(COPY_COUNT))) begin
                    mem_req.wdata = rd_data;
                end else begin
                    mem_req.wdata = {blank_attr, {CHAR_W{1'b0}}};
                end
                if (ptr_reg == PTR_W'(CELL_COUNT)) begin
                    case (mode_reg)
                        SW_INIT:   state_next = ST_IDLE;
                        SW_SCROLL: state_next = (tab_reg != '0) ? ST_GLYPH : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_READ: begin
                data_next  = rd_data;
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    result.valid = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            mode_reg  <= SW_INIT;
            ptr_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            tab_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            ptr_reg   <= ptr_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            tab_reg   <= tab_next;
        end
        char_reg <= char_next;
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: design/text_console_writer.sv
// Text console writer: 80x25 cell store and cursor; depends on tcw_pkg, tcw_seq, tcw_cell_ram.
// Each item passes through the sequencer states to the result register: a printable character
// or tab writes its cells, a backspace blanks one cell, an in-range read waits for RAM data,
// and a scroll or clear walks the whole cell RAM.
// Flow control: one item in flight; a full result register holds it back.
// Reset: cursor to 0, attribute to 0x07, then a clearing pass over the cell RAM with s_ready low.
`default_nettype none

module text_console_writer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration: colour attribute register
    input  wire logic                           cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]     cfg_wr_data,
    // item channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [tcw_pkg::FUNC_W-1:0]     s_func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     s_char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]    s_read_index,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [tcw_pkg::POS_W-1:0]      m_cursor_pos,
    output logic      [tcw_pkg::CELL_W-1:0]     m_cell_data
);

    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic              m_valid_reg;
    logic [POS_W-1:0]  m_cursor_pos_reg;
    cell_t             m_cell_data_reg;

    mem_req_t mem_req;
    result_t  result;
    cell_t    rd_data;
    logic     out_free;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    tcw_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_char_code  (s_char_code),
        .s_read_index (s_read_index),
        .attr         (attr_reg),
        .out_free     (out_free),
        .rd_data      (rd_data),
        .mem_req      (mem_req),
        .result       (result)
    );

    // Cell store: one entry per screen cell, attribute in the high byte.
    tcw_cell_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // Attribute register: taken on any write strobe, no handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= RESET_ATTR;
        end else if (cfg_wr_en) begin
            attr_reg <= cfg_wr_data;
        end
    end

    // Result register: hold until transferred, load when the sequencer finishes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (result.valid) begin
            m_cursor_pos_reg <= result.cursor_pos;
            m_cell_data_reg  <= result.cell_data;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_cursor_pos_reg;
    assign m_cell_data  = m_cell_data_reg;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the 80x25 text console writer (text_console_writer).
// Holds its own screen model, drives a directed script and then random text traffic.
// Depends on tcw_pkg and the text_console_writer RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // The fourth operation code is left unused by the block: it only reports the cursor.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int MAX_INDEX     = (1 << INDEX_W) - 1;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int DRAIN_CYCLES  = 50_000;
    localparam int HOLD_CYCLES   = 400;
    // Each scroll or clear walks the whole cell RAM, so cap how many the random part causes.
    localparam int SWEEP_BUDGET  = 150;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
    } console_op_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        cell_t            data;
    } screen_reply_t;

    typedef struct packed {
        console_op_t   op;
        logic          typed;
        screen_reply_t reply;
    } script_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT wiring
    // ------------------------------------------------------------------
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [ATTR_W-1:0]    cfg_wr_data  = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func       = '0;
    logic [CHAR_W-1:0]    s_char_code  = '0;
    logic [INDEX_W-1:0]   s_read_index = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [POS_W-1:0]     m_cursor_pos;
    logic [CELL_W-1:0]    m_cell_data;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    text_console_writer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_char_code  (s_char_code),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_pos (m_cursor_pos),
        .m_cell_data  (m_cell_data)
    );

    // ------------------------------------------------------------------
    // Screen model: attribute, cell store and cursor, as the block should hold them
    // ------------------------------------------------------------------
    logic [ATTR_W-1:0] shadow_attr;
    cell_t             shadow_cells [CELL_COUNT];
    int unsigned       shadow_col;
    int unsigned       shadow_row;

    screen_reply_t     replies_due [$];

    // Run bookkeeping
    bit          idle_on;
    bit          hold_off_request;
    int unsigned faults;
    int unsigned items_sent;
    int unsigned replies_seen;
    int unsigned sweeps_done;
    int unsigned reads_sent;
    int unsigned cycle_count;
    int unsigned drain_count;
    int unsigned stall_left;
    screen_reply_t got_reply;
    screen_reply_t want_reply;
    script_row_t   script [$];

    function automatic cell_t blank_glyph();
        return {shadow_attr, 8'h00};
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = blank_glyph();
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    // Shift every row up by one and blank the bottom row; the cursor lands on the last row.
    function automatic void scroll_screen();
        for (int i = 0; i < COPY_COUNT; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (int i = COPY_COUNT; i < CELL_COUNT; i++) shadow_cells[i] = blank_glyph();
        shadow_row = ROWS - 1;
    endfunction

    function automatic void settle_cursor();
        if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
        end
        if (shadow_row >= ROWS) scroll_screen();
    endfunction

    function automatic void place_glyph(logic [CHAR_W-1:0] ch);
        int unsigned spot;
        spot = shadow_row * COLUMNS + shadow_col;
        if (spot < CELL_COUNT) shadow_cells[spot] = {shadow_attr, ch};
        shadow_col++;
        settle_cursor();
    endfunction

    function automatic void put_byte(logic [CHAR_W-1:0] ch);
        case (ch)
            CHAR_NEWLINE: begin
                shadow_col = COLUMNS;
                settle_cursor();
            end
            CHAR_RETURN: shadow_col = 0;
            CHAR_BACKSPACE: begin
                // The top-left corner is a dead stop: nothing moves, nothing is blanked.
                if (shadow_col != 0 || shadow_row != 0) begin
                    if (shadow_col == 0) begin
                        shadow_col = COLUMNS - 1;
                        shadow_row--;
                    end else begin
                        shadow_col--;
                    end
                    shadow_cells[shadow_row * COLUMNS + shadow_col] = blank_glyph();
                end
            end
            CHAR_TAB: begin
                for (int i = 0; i < TAB_SPACES; i++) place_glyph(CHAR_SPACE);
            end
            default: place_glyph(ch);
        endcase
    endfunction

    // Advance the model by one operation and return the reply the block must give.
    function automatic screen_reply_t console_apply(console_op_t op);
        screen_reply_t r;
        int unsigned   lin;
        r.data = '0;
        case (op.func)
            FUNC_PUT:   put_byte(op.ch);
            FUNC_CLEAR: blank_screen();
            FUNC_READ:  if (op.idx < CELL_COUNT) r.data = shadow_cells[op.idx];
            default:    ;
        endcase
        lin   = shadow_row * COLUMNS + shadow_col;
        r.pos = lin[POS_W-1:0];
        return r;
    endfunction

    // Number of full RAM walks an operation would trigger from the present cursor.
    function automatic int sweeps_needed(console_op_t op);
        bit bottom;
        bottom = (shadow_row == ROWS - 1);
        if (op.func == FUNC_CLEAR) return 1;
        if (op.func != FUNC_PUT) return 0;
        case (op.ch)
            CHAR_NEWLINE:   return int'(bottom);
            CHAR_RETURN:    return 0;
            CHAR_BACKSPACE: return 0;
            CHAR_TAB:       return int'(bottom && shadow_col >= COLUMNS - TAB_SPACES);
            default:        return int'(bottom && shadow_col == COLUMNS - 1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------
    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Text-like traffic: printable runs broken by control codes, reads and the odd clear.
    function automatic console_op_t pick_op(int nl_pct, int clr_pct);
        console_op_t op;
        int          r;
        int          pick;
        int unsigned lin;
        int unsigned back;
        r        = $urandom_range(0, 99);
        pick     = $urandom_range(0, 99);
        op.func  = FUNC_PUT;
        op.ch    = 8'($urandom_range(32, 126));
        op.idx   = INDEX_W'($urandom_range(0, MAX_INDEX));
        if (r < clr_pct) begin
            op.func = FUNC_CLEAR;
            op.ch   = 8'($urandom_range(0, 255));
        end else if (r < clr_pct + 15) begin
            op.func = FUNC_READ;
            op.ch   = 8'($urandom_range(0, 255));
            lin     = shadow_row * COLUMNS + shadow_col;
            back    = $urandom_range(0, 20);
            if (pick < 60)      op.idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
            else if (pick < 85) op.idx = INDEX_W'((lin > back) ? lin - back : 0);
            else                op.idx = INDEX_W'($urandom_range(CELL_COUNT, MAX_INDEX));
        end else if (r < clr_pct + 15 + nl_pct) begin
            op.ch = CHAR_NEWLINE;
        end else if (pick < 4) begin
            op.ch = CHAR_RETURN;
        end else if (pick < 10) begin
            op.ch = CHAR_BACKSPACE;
        end else if (pick < 15) begin
            op.ch = CHAR_TAB;
        end else if (pick < 16) begin
            op.func = FUNC_UNUSED;
            op.ch   = 8'($urandom_range(0, 255));
        end else if (pick < 32) begin
            op.ch = 8'($urandom_range(0, 255));
        end
        // Out of sweep budget: swap anything that would scroll or clear for a carriage return.
        if (sweeps_needed(op) > 0 && sweeps_done >= SWEEP_BUDGET) begin
            op.func = FUNC_PUT;
            op.ch   = CHAR_RETURN;
        end
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Present one operation, hold it until the transfer, then log what the block owes us.
    task automatic offer_item(console_op_t op, logic typed, screen_reply_t typed_reply);
        int            gap;
        screen_reply_t due;
        gap = idle_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= op.func;
        s_char_code  <= op.ch;
        s_read_index <= op.idx;
        do @(posedge aclk); while (!s_ready);
        sweeps_done += sweeps_needed(op);
        due = console_apply(op);
        // A typed row must agree with the model, and then stands as the expected reply.
        if (typed) begin
            if (due !== typed_reply) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("script row %0d: model gives cursor %0d cell %h, typed %0d %h",
                             items_sent, due.pos, due.data, typed_reply.pos,
                             typed_reply.data);
            end
            due = typed_reply;
        end
        replies_due.push_back(due);
        items_sent++;
        if (op.func == FUNC_READ) reads_sent++;
    endtask

    // Drop valid so that nothing is offered while we wait.
    task automatic hold_back();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // Write the colour attribute with the block idle, then track it in the model.
    task automatic set_attribute(logic [ATTR_W-1:0] attr);
        wait_drained();
        do @(posedge aclk); while (!s_ready);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= attr;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_attr  = attr;
    endtask

    task automatic run_phase(int count, int nl_pct, int clr_pct, bit pause_midway);
        screen_reply_t none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            // Let the block run dry once, then carry on.
            if (pause_midway && n == count / 2) begin
                hold_back();
                wait_drained();
            end
            offer_item(pick_op(nl_pct, clr_pct), 1'b0, none);
        end
        hold_back();
    endtask

    function automatic script_row_t srow(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                                         int idx, logic typed, int pos, int data);
        script_row_t row;
        row.op.func    = func;
        row.op.ch      = ch;
        row.op.idx     = INDEX_W'(idx);
        row.typed      = typed;
        row.reply.pos  = POS_W'(pos);
        row.reply.data = CELL_W'(data);
        return row;
    endfunction

    // Directed script: reset contents, read range limits, extreme bytes, every control
    // code, backspace at top-left and at column 0, wrap at the end of a row, clear.
    task automatic load_script();
        script.push_back(srow(FUNC_READ,   8'h00,          0,         1, 0,  16'h0700));
        script.push_back(srow(FUNC_READ,   8'h00,          1999,      1, 0,  16'h0700));
        script.push_back(srow(FUNC_READ,   8'h00,          MAX_INDEX, 1, 0,  16'h0000));
        script.push_back(srow(FUNC_UNUSED, 8'hFF,          MAX_INDEX, 1, 0,  16'h0000));
        script.push_back(srow(FUNC_PUT,    CHAR_BACKSPACE, 0,         1, 0,  16'h0000));
        script.push_back(srow(FUNC_PUT,    8'h41,          0,         1, 1,  16'h0000));
        script.push_back(srow(FUNC_PUT,    8'h00,          0,         1, 2,  16'h0000));
        script.push_back(srow(FUNC_PUT,    8'hFF,          0,         1, 3,  16'h0000));
        script.push_back(srow(FUNC_READ,   8'h00,          2,         1, 3,  16'h07FF));
        script.push_back(srow(FUNC_PUT,    CHAR_TAB,       0,         1, 7,  16'h0000));
        script.push_back(srow(FUNC_READ,   8'h00,          6,         0, 0,  0));
        script.push_back(srow(FUNC_PUT,    CHAR_BACKSPACE, 0,         0, 0,  0));
        script.push_back(srow(FUNC_PUT,    CHAR_RETURN,    0,         1, 0,  16'h0000));
        script.push_back(srow(FUNC_PUT,    CHAR_NEWLINE,   0,         1, 80, 16'h0000));
        script.push_back(srow(FUNC_PUT,    CHAR_BACKSPACE, 0,         1, 79, 16'h0000));
        script.push_back(srow(FUNC_READ,   8'h00,          79,        1, 79, 16'h0700));
        script.push_back(srow(FUNC_PUT,    8'h7E,          0,         0, 0,  0));
        script.push_back(srow(FUNC_PUT,    CHAR_RETURN,    0,         0, 0,  0));
        script.push_back(srow(FUNC_READ,   8'h00,          80,        0, 0,  0));
        script.push_back(srow(FUNC_CLEAR,  8'h00,          0,         1, 0,  16'h0000));
        script.push_back(srow(FUNC_READ,   8'h00,          2,         1, 0,  16'h0700));
        script.push_back(srow(FUNC_PUT,    8'h80,          0,         0, 0,  0));
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                // Hold ready low long enough for the block to fill and stall its input.
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_request = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Compare every result transfer against the oldest outstanding expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_reply.pos  = m_cursor_pos;
            got_reply.data = m_cell_data;
            replies_seen++;
            if (replies_due.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("unexpected result: cursor %0d cell %h", got_reply.pos,
                             got_reply.data);
            end else begin
                want_reply = replies_due.pop_front();
                if (got_reply.pos !== want_reply.pos) begin
                    faults++;
                    if (faults <= REPORT_LIMIT)
                        $display("result %0d cursor_pos: expected %0d, got %0d",
                                 replies_seen, want_reply.pos, got_reply.pos);
                end
                if (got_reply.data !== want_reply.data) begin
                    faults++;
                    if (faults <= REPORT_LIMIT)
                        $display("result %0d cell_data: expected %h, got %h",
                                 replies_seen, want_reply.data, got_reply.data);
                end
            end
        end
    end

    // Watchdog: the slowest correct run stays well inside this.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     replies_due.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        idle_on          = 1'b1;
        hold_off_request = 1'b0;
        faults           = 0;
        items_sent       = 0;
        replies_seen     = 0;
        sweeps_done      = 0;
        reads_sent       = 0;
        cycle_count      = 0;
        drain_count      = 0;
        shadow_attr      = RESET_ATTR;
        blank_screen();
        load_script();

        // Hold reset, then release it; the block then clears its RAM with s_ready low.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[k]) offer_item(script[k].op, script[k].typed, script[k].reply);
        hold_back();

        // All-zero attribute, moderate newlines and a few clears.
        set_attribute(8'h00);
        run_phase(80, 8, 3, 1'b0);

        // All-ones attribute, heavy newlines to reach the bottom row and scroll,
        // with the receiver stalled for a long stretch at the start.
        set_attribute(8'hFF);
        hold_off_request = 1'b1;
        run_phase(90, 40, 0, 1'b0);

        // No idling on either side: long lines on the bottom row wrap and scroll;
        // the sender drains the block halfway through.
        set_attribute(8'($urandom_range(1, 254)));
        idle_on = 1'b0;
        run_phase(80, 0, 0, 1'b1);
        idle_on = 1'b1;

        set_attribute(8'($urandom_range(0, 255)));
        run_phase(80, 10, 5, 1'b0);

        set_attribute(8'($urandom_range(0, 255)));
        run_phase(70, 15, 2, 1'b0);

        // Wait for the tail to drain, bounded, then allow a little settling time.
        while (replies_due.size() != 0 && drain_count < DRAIN_CYCLES) begin
            @(posedge aclk);
            drain_count++;
        end
        repeat (20) @(posedge aclk);
        if (replies_due.size() != 0) begin
            faults++;
            $display("%0d expected results never arrived", replies_due.size());
        end

        $display("covered %0d transfers in, %0d results out, %0d reads, %0d scrolls/clears",
                 items_sent, replies_seen, reads_sent, sweeps_done);
        $display("five attribute settings including both extremes, %0d mismatches", faults);
        if (faults == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
